### design/pmc_pkg.sv
package pmc_pkg;

	localparam logic [2:0] ACT_MOVE      = 3'd0;
	localparam logic [2:0] ACT_PULL_MOVE = 3'd1;
	localparam logic [2:0] ACT_ENTER     = 3'd2;
	localparam logic [2:0] ACT_LEAVE     = 3'd3;
	localparam logic [2:0] ACT_PULL_IN   = 3'd4;
	localparam logic [2:0] ACT_PULL_OUT  = 3'd5;
	localparam logic [2:0] ACT_DOWN      = 3'd6;
	localparam logic [2:0] ACT_OTHER     = 3'd7;

	localparam logic       REG_IDEAL  = 1'b0;
	localparam logic       REG_EXPIRE = 1'b1;

	localparam logic [15:0] IDEAL_RESET  = 16'd4;
	localparam logic [15:0] EXPIRE_RESET = 16'd24;

	typedef struct packed {
		logic [31:0]        time_ms;
		logic [2:0]         action;
		logic               is_touchpad;
		logic [7:0]         pointer_id;
		logic signed [15:0] raw_dx;
		logic signed [15:0] raw_dy;
	} pmc_in_t;

	typedef struct packed {
		logic [2:0]         out_action;
		logic               out_touchpad;
		logic [7:0]         out_pointer_id;
		logic signed [31:0] out_dx;
		logic signed [31:0] out_dy;
	} pmc_out_t;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [15:0] b);
		logic [32:0] s;
		logic signed [31:0] r;
		s = {a[31], a} + {{17{b[15]}}, b};
		if (s[32] != s[31]) begin
			r = s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

### design/pmc_core.sv
module pmc_core import pmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        step_en,
	input  pmc_in_t     item,
	output logic        emit,
	output pmc_out_t    result
);

	logic [15:0]        ideal_q;
	logic [15:0]        expire_q;
	logic signed [31:0] sum_dx_q;
	logic signed [31:0] sum_dy_q;
	logic [31:0]        last_emit_q;
	logic               emitted_q;
	logic               pending_q;
	logic [31:0]        oldest_q;
	logic [31:0]        newest_q;

	logic               dropped;
	logic               expired;
	logic               pend;
	logic               special;
	logic               interval;
	logic               duration;
	logic               fire;
	logic [31:0]        age_new;
	logic [31:0]        age_emit;
	logic [31:0]        age_old;
	logic signed [31:0] nsum_dx;
	logic signed [31:0] nsum_dy;

	always_comb begin
		dropped  = (item.action >= ACT_ENTER) && (item.action <= ACT_PULL_OUT);
		age_new  = item.time_ms - newest_q;
		age_emit = item.time_ms - last_emit_q;
		age_old  = item.time_ms - oldest_q;
		expired  = age_new > {16'd0, expire_q};
		pend     = pending_q && !expired;
		special  = (item.action != ACT_MOVE) && (item.action != ACT_PULL_MOVE);
		interval = !emitted_q || (age_emit >= {16'd0, ideal_q});
		duration = pend && (age_old >= {16'd0, ideal_q});
		fire     = special || interval || duration;
		nsum_dx  = sat_add(sum_dx_q, item.raw_dx);
		nsum_dy  = sat_add(sum_dy_q, item.raw_dy);
		emit     = !dropped && (item.is_touchpad || fire);
	end

	always_comb begin
		result.out_action     = item.action;
		result.out_touchpad   = item.is_touchpad;
		result.out_pointer_id = item.pointer_id;
		if (item.is_touchpad) begin
			result.out_dx = {{16{item.raw_dx[15]}}, item.raw_dx};
			result.out_dy = {{16{item.raw_dy[15]}}, item.raw_dy};
		end else begin
			result.out_dx = nsum_dx;
			result.out_dy = nsum_dy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ideal_q  <= IDEAL_RESET;
			expire_q <= EXPIRE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IDEAL:  ideal_q  <= cfg_data;
				REG_EXPIRE: expire_q <= cfg_data;
				default:    ideal_q  <= ideal_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_dx_q    <= '0;
			sum_dy_q    <= '0;
			last_emit_q <= '0;
			emitted_q   <= 1'b0;
			pending_q   <= 1'b0;
			oldest_q    <= '0;
			newest_q    <= '0;
		end else if (step_en && !dropped) begin
			pending_q <= pend;
			if (!item.is_touchpad) begin
				if (fire) begin
					pending_q   <= 1'b0;
					last_emit_q <= item.time_ms;
					emitted_q   <= 1'b1;
					sum_dx_q    <= '0;
					sum_dy_q    <= '0;
				end else begin
					sum_dx_q  <= nsum_dx;
					sum_dy_q  <= nsum_dy;
					pending_q <= 1'b1;
					newest_q  <= item.time_ms;
					if (!pend) begin
						oldest_q <= item.time_ms;
					end
				end
			end
		end
	end

endmodule

### design/pointer_motion_coalescer.sv
// channel   direction  handshake            word
// in        input      in_valid / in_stall   in_word (pmc_in_t)
// out       output     out_valid / out_stall out_word (pmc_out_t)
// cfg       input      cfg_wr_en             cfg_index, cfg_data
//
// one word per cycle sustained while the output is not stalled
// the input register feeds the coalescing logic, which writes the result register
// config registers reset to ideal 4 ms and expiry 24 ms, all run state clears
// a stalled result holds the input register; stall on the input follows at once
module pointer_motion_coalescer import pmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  pmc_in_t     in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output pmc_out_t    out_word,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic     valid_s1;
	pmc_in_t  word_s1;
	logic     valid_s2;
	pmc_out_t word_s2;
	logic     advance;
	logic     emit;
	pmc_out_t result;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	pmc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step_en   (valid_s1 && advance),
		.item      (word_s1),
		.emit      (emit),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			word_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

endmodule

### design/pmc_chk.sv
module pmc_chk import pmc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input pmc_out_t out_word
);

	// held word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed");

	// window actions never come out
	a_no_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_word.out_action >= ACT_ENTER &&
			out_word.out_action <= ACT_PULL_OUT))
		else $error("window action emitted");

	// touchpad words carry a raw 16-bit delta
	a_touch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.out_touchpad |->
			(out_word.out_dx[31:15] == '0 || out_word.out_dx[31:15] == '1) &&
			(out_word.out_dy[31:15] == '0 || out_word.out_dy[31:15] == '1))
		else $error("touchpad delta out of raw range");

	// a fresh result must trace back to an accepted input word
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without input word");

endmodule

bind pointer_motion_coalescer pmc_chk u_pmc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
